// ===== sv/maq_pkg.sv =====
package maq_pkg;

    // default width of the internal millisecond time base
    localparam int TIME_BITS_DEFAULT = 32;

    localparam int NOW_BITS       = 32;
    localparam int SKIP_BITS      = 8;
    localparam int MS_BITS        = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [SKIP_BITS-1:0] FRAME_SKIP_RESET = 8'd1;
    localparam logic [MS_BITS-1:0]   PERSIST_RESET    = 16'd1000;
    localparam logic [MS_BITS-1:0]   COOLDOWN_RESET   = 16'd5000;
    localparam logic [MS_BITS-1:0]   GRACE_RESET      = 16'd500;

    // input command codes
    localparam logic CMD_FRAME        = 1'b0;
    localparam logic CMD_STREAM_RESET = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_SKIP = 2'd0,
        REG_PERSIST    = 2'd1,
        REG_COOLDOWN   = 2'd2,
        REG_GRACE      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [SKIP_BITS-1:0] frame_skip;
        logic [MS_BITS-1:0]   persist_ms;
        logic [MS_BITS-1:0]   cooldown_ms;
        logic [MS_BITS-1:0]   grace_ms;
    } cfg_t;

    typedef struct packed {
        logic do_detect;
        logic motion_active;
        logic alarm;
    } result_t;

endpackage

// ===== sv/maq_if.sv =====
interface maq_frame_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        has_target;
    logic [31:0] now_ms;

    modport source (output valid, output command, output has_target, output now_ms,
                    input ready);
    modport sink (input valid, input command, input has_target, input now_ms,
                  output ready);
endinterface

interface maq_result_if;
    logic valid;
    logic ready;
    logic do_detect;
    logic motion_active;
    logic alarm;

    modport source (output valid, output do_detect, output motion_active, output alarm,
                    input ready);
    modport sink (input valid, input do_detect, input motion_active, input alarm,
                  output ready);
endinterface

// ===== sv/maq_core.sv =====
module maq_core #(
    parameter int TIME_BITS = maq_pkg::TIME_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  maq_pkg::cfg_t                   cfg,
    input  logic                            phase_clear,
    input  logic                            step,
    input  logic                            command,
    input  logic                            has_target,
    input  logic [maq_pkg::NOW_BITS-1:0]    now_ms,
    output maq_pkg::result_t                result
);
    import maq_pkg::*;

    logic [SKIP_BITS-1:0] phase_reg, phase_next;
    logic                 motion_reg, motion_next;
    logic                 alarmed_reg, alarmed_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] last_target_reg, last_target_next;
    logic [TIME_BITS-1:0] last_alarm_reg, last_alarm_next;

    logic [TIME_BITS-1:0] now_val;
    logic [SKIP_BITS-1:0] skip_n;
    logic [SKIP_BITS:0]   phase_inc;
    logic                 detect;
    logic                 fire;
    logic [TIME_BITS-1:0] since_target;
    logic [TIME_BITS-1:0] since_start;
    logic [TIME_BITS-1:0] since_alarm;

    assign now_val   = TIME_BITS'(now_ms);
    assign skip_n    = (cfg.frame_skip == '0) ? SKIP_BITS'(1) : cfg.frame_skip;
    assign phase_inc = {1'b0, phase_reg} + (SKIP_BITS+1)'(1);
    assign detect    = (phase_reg == '0);

    always_comb
    begin
        phase_next       = (phase_inc >= {1'b0, skip_n}) ? '0 : phase_inc[SKIP_BITS-1:0];
        motion_next      = motion_reg;
        start_next       = start_reg;
        last_target_next = last_target_reg;
        last_alarm_next  = last_alarm_reg;
        alarmed_next     = alarmed_reg;
        since_target     = now_val - last_target_reg;
        since_alarm      = now_val - last_alarm_reg;

        if (detect)
        begin
            if (has_target)
            begin
                last_target_next = now_val;
                if (!motion_reg)
                begin
                    motion_next = 1'b1;
                    start_next  = now_val;
                end
            end
            else if (motion_reg && (since_target > TIME_BITS'(cfg.grace_ms)))
            begin
                motion_next = 1'b0;
            end
        end

        since_start = now_val - start_next;
        fire = detect && motion_next
            && (since_start >= TIME_BITS'(cfg.persist_ms))
            && (!alarmed_reg || (since_alarm >= TIME_BITS'(cfg.cooldown_ms)));

        if (fire)
        begin
            last_alarm_next = now_val;
            alarmed_next    = 1'b1;
        end

        result.do_detect     = detect;
        result.motion_active = motion_next;
        result.alarm         = fire;

        // stream reset wipes the whole stream state
        if (command == CMD_STREAM_RESET)
        begin
            phase_next       = '0;
            motion_next      = 1'b0;
            start_next       = '0;
            last_target_next = '0;
            last_alarm_next  = '0;
            alarmed_next     = 1'b0;
            result           = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            motion_reg      <= 1'b0;
            start_reg       <= '0;
            last_target_reg <= '0;
            last_alarm_reg  <= '0;
            alarmed_reg     <= 1'b0;
        end
        else if (phase_clear)
        begin
            phase_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            motion_reg      <= motion_next;
            start_reg       <= start_next;
            last_target_reg <= last_target_next;
            last_alarm_reg  <= last_alarm_next;
            alarmed_reg     <= alarmed_next;
        end
    end

endmodule

// ===== sv/motion_alarm_qualifier_unit.sv =====
// motion alarm qualifier
// frame carries one transaction per video frame: command (0 frame event,
// 1 stream reset), has_target from the tracker and now_ms, a wrapping
// millisecond timestamp. result returns exactly one transaction per
// input: do_detect, motion_active and alarm.
// the configuration port writes frame_skip, persist_ms, cooldown_ms and
// grace_ms by index on any cycle with cfg_we high; writes belong in idle
// periods, and writing frame_skip makes the next frame a detection frame.
// a frame accepted into the input register has its result registered in the
// result register once the result slot is free or being drained, and
// result.valid rises with that result.
// throughput: one transaction per cycle unless the receiver stalls; all
// decisions are compares and subtractions on the stream state, evaluated
// in the single pass between the input register and the result register.
// when the receiver stalls, the result register holds and the input register
// absorbs one more frame, after which frame.ready drops.
// reset clears the stream state and both registers' valid flags, and loads the
// register defaults (skip 1, persist 1000 ms, cooldown 5000 ms, grace 500 ms).
module motion_alarm_qualifier_unit #(
    parameter int TIME_BITS = maq_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    maq_frame_if.sink                           frame,
    maq_result_if.source                        result,
    input  logic                                cfg_we,
    input  logic [maq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [maq_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import maq_pkg::*;

    cfg_t            cfg_reg;
    logic            phase_clear;

    // input register
    logic            s1_valid_reg;
    logic            s1_command_reg;
    logic            s1_target_reg;
    logic [NOW_BITS-1:0] s1_now_reg;

    // result register
    logic            out_valid_reg;
    result_t         out_reg;

    result_t         core_result;
    logic            advance;

    // the held frame moves on whenever the result slot is free or being drained
    assign advance     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready = !s1_valid_reg || advance;

    assign phase_clear = cfg_we && (cfg_reg_t'(cfg_index) == REG_FRAME_SKIP);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_skip  <= FRAME_SKIP_RESET;
            cfg_reg.persist_ms  <= PERSIST_RESET;
            cfg_reg.cooldown_ms <= COOLDOWN_RESET;
            cfg_reg.grace_ms    <= GRACE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_SKIP: cfg_reg.frame_skip  <= cfg_wdata[SKIP_BITS-1:0];
                REG_PERSIST:    cfg_reg.persist_ms  <= cfg_wdata[MS_BITS-1:0];
                REG_COOLDOWN:   cfg_reg.cooldown_ms <= cfg_wdata[MS_BITS-1:0];
                REG_GRACE:      cfg_reg.grace_ms    <= cfg_wdata[MS_BITS-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register: valid under reset, payload free-running on capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            s1_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            s1_command_reg <= frame.command;
            s1_target_reg  <= frame.has_target;
            s1_now_reg     <= frame.now_ms;
        end
    end

    maq_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .phase_clear (phase_clear),
        .step        (advance),
        .command     (s1_command_reg),
        .has_target  (s1_target_reg),
        .now_ms      (s1_now_reg),
        .result      (core_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= core_result;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.do_detect     = out_reg.do_detect;
    assign result.motion_active = out_reg.motion_active;
    assign result.alarm         = out_reg.alarm;

    // an alarm only ever fires on a detection frame with motion active
    a_alarm_needs_motion: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.alarm |-> out_reg.do_detect && out_reg.motion_active)
        else $error("alarm without detection and motion");

    // an empty input register always takes a frame
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> frame.ready)
        else $error("input stalled while input register empty");

    // a held frame stays held while the result slot is blocked
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !result.ready |=> s1_valid_reg)
        else $error("held frame lost during stall");

    // a stream reset always yields an all-zero result
    a_stream_reset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_command_reg == CMD_STREAM_RESET) |=> (out_reg == '0))
        else $error("stream reset result not cleared");

endmodule
